@@ hdl/scpa_pkg.sv @@
// Shared types and constants for the size class pool allocator.
// No dependencies; imported by scpa_fit_unit and the top level.
`timescale 1ns / 1ps
`default_nettype none

package scpa_pkg;

   // Registers that exist whatever the shelf count parameter is
   localparam int REG_SHELVES      = 4;
   localparam int DEF_NUM_SHELVES  = 4;
   localparam int DEF_CHUNKS       = 256;
   localparam int CHUNK_CAP_MAX    = 256;

   localparam int SIZE_W    = 5;
   localparam int COUNT_W   = 9;
   localparam int REQ_W     = 20;
   localparam int SHELF_W   = 2;
   localparam int CHUNK_W   = 8;
   localparam int TOTAL_W   = 32;
   localparam int CSR_IDX_W = 4;
   localparam int MIN_LOG2  = 4;

   localparam logic [COUNT_W-1:0] EMPTY_MARK = 9'h100;
   localparam logic [COUNT_W-1:0] LEFT_MAX   = 9'h1FF;

   // Register map
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE0  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT0 = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LAST   = 4'd7;

   // Request modes (anything else acts as a query)
   localparam logic [1:0] MODE_ALLOC = 2'd0;
   localparam logic [1:0] MODE_FREE  = 2'd1;
   localparam logic [1:0] MODE_QUERY = 2'd2;

   // Response status codes
   localparam logic [1:0] STAT_OK       = 2'd0;
   localparam logic [1:0] STAT_NO_SHELF = 2'd1;
   localparam logic [1:0] STAT_EMPTY    = 2'd2;

   typedef logic [SIZE_W-1:0]  size_log2_type;
   typedef logic [COUNT_W-1:0] count_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_FINISH
   } scpa_state_type;

   // Outcome of the shelf search
   typedef struct packed {
      logic               done;
      logic               fits;
      logic [SHELF_W-1:0] shelf;
   } fit_result_type;

endpackage

`default_nettype wire

@@ hdl/scpa_ram.sv @@
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module scpa_ram #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hdl/scpa_fit_unit.sv @@
// Shelf search: one size compare per cycle, walking shelves in index order.
// Depends on scpa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scpa_fit_unit #(
   parameter int SHELVES = 4
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire logic [scpa_pkg::REQ_W-1:0]     request_size,
   input  wire scpa_pkg::size_log2_type        size_log2 [scpa_pkg::REG_SHELVES],
   output scpa_pkg::fit_result_type            result
);

   import scpa_pkg::*;

   logic               busy_ff, busy_in;
   logic [SHELF_W-1:0] idx_ff, idx_in;
   logic [REQ_W-1:0]   req_ff;
   logic [SIZE_W-1:0]  log2_eff;
   logic               fits;
   logic               last;

   // Chunk size 2^l with l clamped to at least 16 bytes
   always_comb begin
      log2_eff = size_log2[idx_ff];
      if (log2_eff < SIZE_W'(MIN_LOG2)) begin
         log2_eff = SIZE_W'(MIN_LOG2);
      end
      if (log2_eff >= SIZE_W'(REQ_W)) begin
         fits = 1'b1;
      end else begin
         fits = ({1'b0, req_ff} <= ((REQ_W+1)'(1) << log2_eff));
      end
      last = (idx_ff == SHELF_W'(SHELVES - 1));
   end

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (start) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (busy_ff) begin
         if (fits || last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + SHELF_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         req_ff <= request_size;
      end
   end

   assign result.done  = busy_ff && (fits || last);
   assign result.fits  = fits;
   assign result.shelf = idx_ff;

endmodule

`default_nettype wire

@@ hdl/size_class_pool_allocator_unit.sv @@
// Top level of the size class pool allocator: sequencer, shelf state, output slot.
// Depends on scpa_pkg, scpa_fit_unit and scpa_ram.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake             Beat contents
// req_*     in   req_valid/req_ready   mode, request_size, shelf_index, chunk_index
// rsp_*     out  rsp_valid/rsp_ready   status, shelf, chunk, shelf figures, largest
// csr_*     in   csr_wr_en             register index, write data (no wait)
//
// Free and query beats pass through accept and finish. An allocate adds
// a search step between them: the fit unit compares one shelf size per cycle
// until the first fit; the link RAM read for a free-list pop overlaps the
// last compare. Reset is synchronous; the link RAM needs no clearing.
// The finish step stalls while the previous response beat is still held;
// a new request is taken as soon as the sequencer is back in idle.

module size_class_pool_allocator_unit #(
   parameter int NUM_SHELVES      = scpa_pkg::DEF_NUM_SHELVES,
   parameter int CHUNKS_PER_SHELF = scpa_pkg::DEF_CHUNKS
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request channel
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [1:0]                       req_mode,
   input  wire logic [scpa_pkg::REQ_W-1:0]       req_request_size,
   input  wire logic [scpa_pkg::SHELF_W-1:0]     req_shelf_index,
   input  wire logic [scpa_pkg::CHUNK_W-1:0]     req_chunk_index,
   // response channel
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [1:0]                            rsp_status,
   output logic [scpa_pkg::SHELF_W-1:0]          rsp_result_shelf,
   output logic [scpa_pkg::CHUNK_W-1:0]          rsp_result_chunk,
   output logic [scpa_pkg::COUNT_W-1:0]          rsp_chunks_left,
   output logic [scpa_pkg::COUNT_W-1:0]          rsp_chunks_left_min,
   output logic [scpa_pkg::TOTAL_W-1:0]          rsp_alloc_total,
   output logic [scpa_pkg::TOTAL_W-1:0]          rsp_free_total,
   output logic [scpa_pkg::TOTAL_W-1:0]          rsp_fail_total,
   output logic [scpa_pkg::REQ_W-1:0]            rsp_largest_request,
   // configuration port
   input  wire logic                             csr_wr_en,
   input  wire logic [scpa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [scpa_pkg::COUNT_W-1:0]     csr_wr_data
);

   import scpa_pkg::*;

   // Shelves backed by state, and chunks per shelf
   localparam int ACTIVE = (NUM_SHELVES < REG_SHELVES) ? NUM_SHELVES : REG_SHELVES;
   localparam int CAP    = (CHUNKS_PER_SHELF < CHUNK_CAP_MAX) ?
                           CHUNKS_PER_SHELF : CHUNK_CAP_MAX;
   localparam int SEL_W  = (ACTIVE > 1) ? $clog2(ACTIVE) : 1;
   localparam int DEPTH  = ACTIVE * CAP;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [COUNT_W-1:0] CAP_C = COUNT_W'(CAP);

   function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
      return (v == '1) ? v : v + TOTAL_W'(1);
   endfunction

   function automatic logic [COUNT_W-1:0] cap_count(input logic [COUNT_W-1:0] c);
      return (c < CAP_C) ? c : CAP_C;
   endfunction

   function automatic logic [ADDR_W-1:0] link_addr(input logic [SHELF_W-1:0] s,
                                                   input logic [CHUNK_W-1:0] c);
      return ADDR_W'(int'(s) * CAP + int'(c));
   endfunction

   // ---------------- configuration registers ----------------
   size_log2_type size_log2_ff [REG_SHELVES];
   count_type     count_reg_ff [REG_SHELVES];

   // ---------------- per-shelf state ----------------
   count_type          head_ff [ACTIVE], head_in [ACTIVE];
   count_type          fresh_ff [ACTIVE], fresh_in [ACTIVE];
   count_type          left_ff [ACTIVE], left_in [ACTIVE];
   count_type          low_ff [ACTIVE], low_in [ACTIVE];
   logic [TOTAL_W-1:0] alloc_ff [ACTIVE], alloc_in [ACTIVE];
   logic [TOTAL_W-1:0] free_ff [ACTIVE], free_in [ACTIVE];
   logic [TOTAL_W-1:0] fail_ff [ACTIVE], fail_in [ACTIVE];
   logic [REQ_W-1:0]   largest_ff, largest_in;

   // ---------------- sequencer and item registers ----------------
   scpa_state_type     state_ff, state_in;
   logic [1:0]         mode_ff;
   logic [REQ_W-1:0]   size_ff;
   logic [CHUNK_W-1:0] chunk_ff;
   logic [SHELF_W-1:0] cur_sh_ff;
   logic               fits_ff;
   logic               pop_ff;

   // ---------------- output slot ----------------
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         out_status_ff, out_status_in;
   logic [SHELF_W-1:0] out_shelf_ff;
   logic [CHUNK_W-1:0] out_chunk_ff, out_chunk_in;
   count_type          out_left_ff, out_low_ff;
   logic [TOTAL_W-1:0] out_alloc_ff, out_free_ff, out_fail_ff;
   logic [REQ_W-1:0]   out_largest_ff;

   // ---------------- control signals ----------------
   logic               req_accept;
   logic               out_free;
   logic               finish_go;
   logic               fit_start;
   fit_result_type     fit;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [COUNT_W-1:0] rd_data;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic [COUNT_W-1:0] wr_data;
   logic [SHELF_W-1:0] req_sh_clamped;
   logic [SEL_W-1:0]   fit_sel;
   logic [SEL_W-1:0]   cur_sel;
   logic [COUNT_W-1:0] cur_count;
   logic [SHELF_W-1:0] csr_shelf;

   assign req_accept = req_valid && req_ready;
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign fit_sel    = fit.shelf[SEL_W-1:0];
   assign cur_sel    = cur_sh_ff[SEL_W-1:0];
   assign cur_count  = cap_count(count_reg_ff[cur_sh_ff]);
   assign csr_shelf  = SHELF_W'(csr_index - CSR_COUNT0);
   assign req_sh_clamped = (int'(req_shelf_index) >= ACTIVE) ?
                           SHELF_W'(ACTIVE - 1) : req_shelf_index;

   // ---------------- shared shelf search unit ----------------
   scpa_fit_unit #(
      .SHELVES (ACTIVE)
   ) u_fit (
      .clock        (clock),
      .reset        (reset),
      .start        (fit_start),
      .request_size (req_request_size),
      .size_log2    (size_log2_ff),
      .result       (fit)
   );

   // ---------------- link store ----------------
   scpa_ram #(
      .WIDTH (COUNT_W),
      .DEPTH (DEPTH)
   ) u_link (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = (req_mode == MODE_ALLOC) ? ST_SEARCH : ST_FINISH;
            end
         end
         ST_SEARCH: begin
            if (fit.done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------- sequencer outputs ----------------
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      fit_start = req_accept && (req_mode == MODE_ALLOC);
      finish_go = (state_ff == ST_FINISH) && out_free;
      // Pop read overlaps the last compare; the head holds until finish
      rd_en   = (state_ff == ST_SEARCH) && fit.done && fit.fits &&
                (head_ff[fit_sel] != EMPTY_MARK) &&
                ({1'b0, head_ff[fit_sel][CHUNK_W-1:0]} < CAP_C);
      rd_addr = link_addr(fit.shelf, head_ff[fit_sel][CHUNK_W-1:0]);
   end

   // ---------------- shelf updates ----------------
   always_comb begin
      head_in    = head_ff;
      fresh_in   = fresh_ff;
      left_in    = left_ff;
      low_in     = low_ff;
      alloc_in   = alloc_ff;
      free_in    = free_ff;
      fail_in    = fail_ff;
      largest_in = largest_ff;
      out_status_in = STAT_OK;
      out_chunk_in  = '0;
      wr_en   = 1'b0;
      wr_addr = link_addr(cur_sh_ff, chunk_ff);
      wr_data = head_ff[cur_sel];

      if (finish_go) begin
         case (mode_ff)
            MODE_ALLOC: begin
               if (size_ff > largest_ff) begin
                  largest_in = size_ff;
               end
               if (!fits_ff) begin
                  out_status_in = STAT_NO_SHELF;
               end else if (head_ff[cur_sel] != EMPTY_MARK) begin
                  out_chunk_in     = head_ff[cur_sel][CHUNK_W-1:0];
                  head_in[cur_sel] = pop_ff ? rd_data : EMPTY_MARK;
               end else if (fresh_ff[cur_sel] < cur_count) begin
                  out_chunk_in      = fresh_ff[cur_sel][CHUNK_W-1:0];
                  fresh_in[cur_sel] = fresh_ff[cur_sel] + COUNT_W'(1);
               end else begin
                  out_status_in    = STAT_EMPTY;
                  fail_in[cur_sel] = sat_inc(fail_ff[cur_sel]);
               end
               if (fits_ff && (out_status_in == STAT_OK)) begin
                  if (left_ff[cur_sel] != '0) begin
                     left_in[cur_sel] = left_ff[cur_sel] - COUNT_W'(1);
                  end
                  if (left_in[cur_sel] < low_ff[cur_sel]) begin
                     low_in[cur_sel] = left_in[cur_sel];
                  end
                  alloc_in[cur_sel] = sat_inc(alloc_ff[cur_sel]);
               end
            end
            MODE_FREE: begin
               // Chunks at or beyond the shelf count are ignored
               if ({1'b0, chunk_ff} < cur_count) begin
                  wr_en            = 1'b1;
                  head_in[cur_sel] = {1'b0, chunk_ff};
                  if (left_ff[cur_sel] < LEFT_MAX) begin
                     left_in[cur_sel] = left_ff[cur_sel] + COUNT_W'(1);
                  end
                  free_in[cur_sel] = sat_inc(free_ff[cur_sel]);
               end
            end
            default: begin
               // query: figures only
            end
         endcase
      end

      // Count write reinitializes that shelf
      if (csr_wr_en && (csr_index >= CSR_COUNT0) && (csr_index <= CSR_LAST)) begin
         for (int s = 0; s < ACTIVE; s++) begin
            if (csr_shelf == SHELF_W'(s)) begin
               head_in[s]  = EMPTY_MARK;
               fresh_in[s] = '0;
               left_in[s]  = cap_count(csr_wr_data);
               low_in[s]   = cap_count(csr_wr_data);
               alloc_in[s] = '0;
               free_in[s]  = '0;
               fail_in[s]  = '0;
            end
         end
      end

      rsp_valid_in = rsp_valid_ff;
      if (finish_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         largest_ff   <= '0;
         for (int s = 0; s < REG_SHELVES; s++) begin
            size_log2_ff[s] <= SIZE_W'(MIN_LOG2 + s);
            count_reg_ff[s] <= COUNT_W'(CHUNK_CAP_MAX);
         end
         for (int s = 0; s < ACTIVE; s++) begin
            head_ff[s]  <= EMPTY_MARK;
            fresh_ff[s] <= '0;
            left_ff[s]  <= CAP_C;
            low_ff[s]   <= CAP_C;
            alloc_ff[s] <= '0;
            free_ff[s]  <= '0;
            fail_ff[s]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         largest_ff   <= largest_in;
         if (csr_wr_en && (csr_index < CSR_COUNT0)) begin
            size_log2_ff[csr_index[SHELF_W-1:0]] <= csr_wr_data[SIZE_W-1:0];
         end
         if (csr_wr_en && (csr_index >= CSR_COUNT0) && (csr_index <= CSR_LAST)) begin
            count_reg_ff[csr_shelf] <= csr_wr_data;
         end
         head_ff  <= head_in;
         fresh_ff <= fresh_in;
         left_ff  <= left_in;
         low_ff   <= low_in;
         alloc_ff <= alloc_in;
         free_ff  <= free_in;
         fail_ff  <= fail_in;
      end
   end

   // ---------------- item and response payload ----------------
   always_ff @(posedge clock) begin
      if (req_accept) begin
         mode_ff   <= req_mode;
         size_ff   <= req_request_size;
         chunk_ff  <= req_chunk_index;
         cur_sh_ff <= req_sh_clamped;
         fits_ff   <= 1'b1;
         pop_ff    <= 1'b0;
      end else if ((state_ff == ST_SEARCH) && fit.done) begin
         cur_sh_ff <= fit.shelf;
         fits_ff   <= fit.fits;
         pop_ff    <= rd_en;
      end
      if (finish_go) begin
         out_status_ff  <= out_status_in;
         out_shelf_ff   <= cur_sh_ff;
         out_chunk_ff   <= out_chunk_in;
         out_left_ff    <= left_in[cur_sel];
         out_low_ff     <= low_in[cur_sel];
         out_alloc_ff   <= alloc_in[cur_sel];
         out_free_ff    <= free_in[cur_sel];
         out_fail_ff    <= fail_in[cur_sel];
         out_largest_ff <= largest_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = out_status_ff;
   assign rsp_result_shelf    = out_shelf_ff;
   assign rsp_result_chunk    = out_chunk_ff;
   assign rsp_chunks_left     = out_left_ff;
   assign rsp_chunks_left_min = out_low_ff;
   assign rsp_alloc_total     = out_alloc_ff;
   assign rsp_free_total      = out_free_ff;
   assign rsp_fail_total      = out_fail_ff;
   assign rsp_largest_request = out_largest_ff;

endmodule

`default_nettype wire

@@ sim/size_class_pool_allocator_unit_tb.sv @@
// Self-checking testbench for size_class_pool_allocator_unit: directed and random
// allocate/free/query traffic against a cycle-free shelf model held in a scoreboard.
// Depends on scpa_pkg and the block's RTL only.
`timescale 1ns / 1ps

module size_class_pool_allocator_unit_tb;
   import scpa_pkg::*;

   // Block geometry as instantiated (defaults)
   localparam int ACTIVE_SHELVES = DEF_NUM_SHELVES;
   localparam int CHUNK_CAP      =
      (DEF_CHUNKS < CHUNK_CAP_MAX) ? DEF_CHUNKS : CHUNK_CAP_MAX;
   localparam logic [1:0] MODE_QUERY_ALT = 2'd3;   // undefined mode, acts as a query

   localparam int SETTLE_CYCLES   = 8;    // extra wait once no beat is owed
   localparam int HOLD_OFF_CYCLES = 300;  // long receiver stall, fills the block

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   typedef enum int {MIX_BALANCED, MIX_FREE_HEAVY} traffic_mix_type;

   // One response beat, in port order
   typedef struct packed {
      logic [1:0]         status;
      logic [SHELF_W-1:0] result_shelf;
      logic [CHUNK_W-1:0] result_chunk;
      logic [COUNT_W-1:0] chunks_left;
      logic [COUNT_W-1:0] chunks_left_min;
      logic [TOTAL_W-1:0] alloc_total;
      logic [TOTAL_W-1:0] free_total;
      logic [TOTAL_W-1:0] fail_total;
      logic [REQ_W-1:0]   largest_request;
   } alloc_beat_type;

   // Shelf model plus the queue of response beats still owed by the block.
   class pool_scoreboard;
      size_log2_type      size_reg[ACTIVE_SHELVES];
      count_type          count_reg[ACTIVE_SHELVES];
      logic [COUNT_W-1:0] link_mem[ACTIVE_SHELVES*CHUNK_CAP];
      logic [COUNT_W-1:0] head[ACTIVE_SHELVES];
      logic [COUNT_W-1:0] fresh[ACTIVE_SHELVES];
      logic [COUNT_W-1:0] left[ACTIVE_SHELVES];
      logic [COUNT_W-1:0] low_mark[ACTIVE_SHELVES];
      logic [TOTAL_W-1:0] allocs[ACTIVE_SHELVES];
      logic [TOTAL_W-1:0] frees[ACTIVE_SHELVES];
      logic [TOTAL_W-1:0] fails[ACTIVE_SHELVES];
      logic [REQ_W-1:0]   largest;
      alloc_beat_type     owed_q[$];
      int errors, checked, n_alloc, n_free, n_query, n_empty, n_no_shelf, n_settings;

      function count_type shelf_chunks(int s);
         return (count_reg[s] < CHUNK_CAP) ? count_reg[s] : count_type'(CHUNK_CAP);
      endfunction

      function logic [32:0] shelf_bytes(int s);
         int l;
         l = size_reg[s];
         if (l < MIN_LOG2) l = MIN_LOG2;
         return 33'd1 << l;
      endfunction

      function logic [TOTAL_W-1:0] bump(logic [TOTAL_W-1:0] v);
         return (v == '1) ? v : v + 1'b1;
      endfunction

      function void init_shelf(int s);
         head[s]     = EMPTY_MARK;
         fresh[s]    = '0;
         left[s]     = shelf_chunks(s);
         low_mark[s] = shelf_chunks(s);
         allocs[s]   = '0;
         frees[s]    = '0;
         fails[s]    = '0;
      endfunction

      function void reset_state();
         for (int s = 0; s < ACTIVE_SHELVES; s++) begin
            size_reg[s]  = size_log2_type'(MIN_LOG2 + s);
            count_reg[s] = count_type'(CHUNK_CAP_MAX);
            init_shelf(s);
         end
         foreach (link_mem[i]) link_mem[i] = '0;
         largest = '0;
      endfunction

      function void write_reg(csr_idx_type idx, count_type data);
         int s;
         if (idx < CSR_COUNT0) begin
            size_reg[idx] = data[SIZE_W-1:0];
         end else if (idx <= CSR_LAST) begin
            s = idx - CSR_COUNT0;
            count_reg[s] = data;
            init_shelf(s);   // count write re-initializes the shelf
         end
      endfunction

      // Apply one accepted request beat; returns the response it must produce.
      function alloc_beat_type note_request(logic [1:0] mode, logic [REQ_W-1:0] size,
                                            logic [SHELF_W-1:0] shelf_in,
                                            logic [CHUNK_W-1:0] chunk);
         alloc_beat_type e;
         int s;
         e = '0;
         s = shelf_in;
         if (s >= ACTIVE_SHELVES) s = ACTIVE_SHELVES - 1;
         if (mode == MODE_ALLOC) begin
            n_alloc++;
            if (size > largest) largest = size;
            s = 0;
            while (s < ACTIVE_SHELVES - 1 && shelf_bytes(s) < size) s++;
            if (shelf_bytes(s) < size) begin
               e.status = STAT_NO_SHELF;
               n_no_shelf++;
            end else if (head[s] != EMPTY_MARK) begin
               e.result_chunk = head[s][CHUNK_W-1:0];
               head[s] = link_mem[s*CHUNK_CAP + head[s][CHUNK_W-1:0]];
            end else if (fresh[s] < shelf_chunks(s)) begin
               e.result_chunk = fresh[s][CHUNK_W-1:0];
               fresh[s]++;
            end else begin
               e.status = STAT_EMPTY;
               fails[s] = bump(fails[s]);
               n_empty++;
            end
            if (e.status == STAT_OK) begin
               if (left[s] != 0) left[s]--;
               if (left[s] < low_mark[s]) low_mark[s] = left[s];
               allocs[s] = bump(allocs[s]);
            end
         end else if (mode == MODE_FREE) begin
            n_free++;
            if (chunk < shelf_chunks(s)) begin
               link_mem[s*CHUNK_CAP + chunk] = head[s];
               head[s] = {1'b0, chunk};
               if (left[s] != LEFT_MAX) left[s]++;
               frees[s] = bump(frees[s]);
            end
         end else begin
            n_query++;
         end
         e.result_shelf    = SHELF_W'(s);
         e.chunks_left     = left[s];
         e.chunks_left_min = low_mark[s];
         e.alloc_total     = allocs[s];
         e.free_total      = frees[s];
         e.fail_total      = fails[s];
         e.largest_request = largest;
         owed_q.push_back(e);
         return e;
      endfunction

      function void compare_field(string name, logic [TOTAL_W-1:0] want,
                                  logic [TOTAL_W-1:0] got);
         if (got !== want) begin
            errors++;
            $error("%s: expected %0d, got %0d", name, want, got);
         end
      endfunction

      function void check_beat(alloc_beat_type got);
         alloc_beat_type want;
         if (owed_q.size() == 0) begin
            errors++;
            $error("response beat with no request outstanding");
            return;
         end
         want = owed_q.pop_front();
         checked++;
         compare_field("status",          want.status,          got.status);
         compare_field("result_shelf",    want.result_shelf,    got.result_shelf);
         compare_field("result_chunk",    want.result_chunk,    got.result_chunk);
         compare_field("chunks_left",     want.chunks_left,     got.chunks_left);
         compare_field("chunks_left_min", want.chunks_left_min, got.chunks_left_min);
         compare_field("alloc_total",     want.alloc_total,     got.alloc_total);
         compare_field("free_total",      want.free_total,      got.free_total);
         compare_field("fail_total",      want.fail_total,      got.fail_total);
         compare_field("largest_request", want.largest_request, got.largest_request);
      endfunction

      function int pending();
         return owed_q.size();
      endfunction
   endclass

   // ---------------------------------------------------------------------
   // Clock, DUT signals
   // ---------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset;
   always #10 clock = ~clock;

   logic                 req_valid, req_ready;
   logic [1:0]           req_mode;
   logic [REQ_W-1:0]     req_request_size;
   logic [SHELF_W-1:0]   req_shelf_index;
   logic [CHUNK_W-1:0]   req_chunk_index;
   logic                 rsp_valid, rsp_ready;
   logic [1:0]           rsp_status;
   logic [SHELF_W-1:0]   rsp_result_shelf;
   logic [CHUNK_W-1:0]   rsp_result_chunk;
   logic [COUNT_W-1:0]   rsp_chunks_left, rsp_chunks_left_min;
   logic [TOTAL_W-1:0]   rsp_alloc_total, rsp_free_total, rsp_fail_total;
   logic [REQ_W-1:0]     rsp_largest_request;
   logic                 csr_wr_en;
   csr_idx_type          csr_index;
   count_type            csr_wr_data;

   size_class_pool_allocator_unit u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_mode            (req_mode),
      .req_request_size    (req_request_size),
      .req_shelf_index     (req_shelf_index),
      .req_chunk_index     (req_chunk_index),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_status          (rsp_status),
      .rsp_result_shelf    (rsp_result_shelf),
      .rsp_result_chunk    (rsp_result_chunk),
      .rsp_chunks_left     (rsp_chunks_left),
      .rsp_chunks_left_min (rsp_chunks_left_min),
      .rsp_alloc_total     (rsp_alloc_total),
      .rsp_free_total      (rsp_free_total),
      .rsp_fail_total      (rsp_fail_total),
      .rsp_largest_request (rsp_largest_request),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wr_data         (csr_wr_data)
   );

   pool_scoreboard    sb;
   logic [CHUNK_W-1:0] held_q[ACTIVE_SHELVES][$];  // chunks handed out, candidates to free
   logic              hold_off_req;                // main asks receiver for a long stall
   int                burst_left;

   // ---------------------------------------------------------------------
   // Response side: sample at rising edge, ready changes at falling edge
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_beat(alloc_beat_type'({rsp_status, rsp_result_shelf, rsp_result_chunk,
                                         rsp_chunks_left, rsp_chunks_left_min,
                                         rsp_alloc_total, rsp_free_total,
                                         rsp_fail_total, rsp_largest_request}));
   end

   // Receiver stall pattern: rotates through always-ready, a fixed 2-of-3
   // duty, coin flips and rare single-cycle stalls.
   initial begin
      int rsp_cycle;
      rsp_cycle = 0;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_off_req) begin
            // long stall counted here; the block backs up and drops req_ready
            rsp_ready = 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_req = 1'b0;
         end
         rsp_cycle++;
         case (rsp_cycle[7:6])
            2'd0:    rsp_ready = 1'b1;
            2'd1:    rsp_ready = (rsp_cycle % 3) != 0;
            2'd2:    rsp_ready = $urandom_range(0, 1);
            default: rsp_ready = $urandom_range(0, 7) != 0;
         endcase
         @(negedge clock);
      end
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // Present one beat at the falling edge and hold it until taken.
   task automatic offer_request(input logic [1:0] mode, input logic [REQ_W-1:0] size,
                                input logic [SHELF_W-1:0] shelf,
                                input logic [CHUNK_W-1:0] chunk);
      alloc_beat_type e;
      @(negedge clock);
      req_valid        = 1'b1;
      req_mode         = mode;
      req_request_size = size;
      req_shelf_index  = shelf;
      req_chunk_index  = chunk;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      e = sb.note_request(mode, size, shelf, chunk);
      if (mode == MODE_ALLOC && e.status == STAT_OK)
         held_q[e.result_shelf].push_back(e.result_chunk);
   endtask

   task automatic idle_sender(input int cycles);
      @(negedge clock);
      req_valid = 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Bursts of 1..40 beats, then an idle gap that is sometimes left out
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) idle_sender(gap);
         burst_left = $urandom_range(1, 40);
      end
   endtask

   // Stop offering and wait out every owed beat, plus the block's latency.
   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_idx_type idx, input count_type data);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_index   = idx;
      csr_wr_data = data;
      @(posedge clock);
      sb.write_reg(idx, data);
      if (idx >= CSR_COUNT0) held_q[idx - CSR_COUNT0].delete();
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // New pool setting: only with the block idle
   task automatic configure_pool(input size_log2_type s0, s1, s2, s3,
                                 input count_type c0, c1, c2, c3);
      size_log2_type sz[ACTIVE_SHELVES];
      count_type     cnt[ACTIVE_SHELVES];
      sz  = '{s0, s1, s2, s3};
      cnt = '{c0, c1, c2, c3};
      drain_results();
      for (int s = 0; s < ACTIVE_SHELVES; s++) begin
         write_csr(CSR_SIZE0 + csr_idx_type'(s), count_type'(sz[s]));
         write_csr(CSR_COUNT0 + csr_idx_type'(s), cnt[s]);
      end
      sb.n_settings++;
   endtask

   task automatic random_request(input traffic_mix_type mix);
      int                 roll, s, pick, l;
      logic [32:0]        edge_size;
      logic [1:0]         mode;
      logic [REQ_W-1:0]   size;
      logic [SHELF_W-1:0] shelf;
      logic [CHUNK_W-1:0] chunk;
      roll  = $urandom_range(0, 99);
      // unused fields always carry noise
      size  = REQ_W'($urandom_range(0, (1 << REQ_W) - 1));
      shelf = SHELF_W'($urandom_range(0, ACTIVE_SHELVES - 1));
      chunk = CHUNK_W'($urandom_range(0, 255));
      if (mix == MIX_FREE_HEAVY) begin
         // pile frees on the last shelf to drive its vacant count to saturation
         mode = (roll < 85) ? MODE_FREE : (roll < 95) ? MODE_ALLOC : MODE_QUERY;
         if (mode == MODE_FREE && $urandom_range(0, 19) != 0) shelf = SHELF_W'(3);
      end else begin
         mode = (roll < 45) ? MODE_ALLOC : (roll < 80) ? MODE_FREE :
                (roll < 95) ? MODE_QUERY : MODE_QUERY_ALT;
         if (mode == MODE_FREE && $urandom_range(0, 3) != 0) begin
            // mostly give back something that was handed out
            s = $urandom_range(0, ACTIVE_SHELVES - 1);
            for (int k = 0; k < ACTIVE_SHELVES && held_q[s].size() == 0; k++)
               s = (s + 1) % ACTIVE_SHELVES;
            if (held_q[s].size() != 0) begin
               pick  = $urandom_range(0, held_q[s].size() - 1);
               shelf = SHELF_W'(s);
               chunk = held_q[s][pick];
               held_q[s].delete(pick);
            end
         end else if (mode == MODE_FREE && roll[0]) begin
            // near the shelf's count: in range, at the edge, or just past it
            chunk = CHUNK_W'($urandom_range(0, sb.shelf_chunks(shelf)));
         end
      end
      if (mode == MODE_ALLOC) begin
         pick = $urandom_range(0, 9);
         if (pick >= 1 && pick <= 2) begin
            // exactly a shelf size, or one byte more
            edge_size = sb.shelf_bytes($urandom_range(0, ACTIVE_SHELVES - 1))
                        + 33'($urandom_range(0, 1));
            size = (edge_size > 33'((1 << REQ_W) - 1)) ? '1 : edge_size[REQ_W-1:0];
         end else if (pick != 0) begin
            l    = $urandom_range(0, 17);
            size = REQ_W'($urandom_range(0, 1 << l));
         end
      end
      offer_request(mode, size, shelf, chunk);
      pace_sender();
   endtask

   task automatic run_traffic(input int beats, input traffic_mix_type mix);
      repeat (beats) random_request(mix);
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      sb = new();
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_mode         = MODE_ALLOC;
      req_request_size = '0;
      req_shelf_index  = '0;
      req_chunk_index  = '0;
      csr_wr_en        = 1'b0;
      csr_index        = CSR_SIZE0;
      csr_wr_data      = '0;
      hold_off_req     = 1'b0;
      burst_left       = 1;
      sb.reset_state();
      sb.n_settings    = 1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset setting: shelves of 16/32/64/128 bytes, 256 chunks each
      offer_request(MODE_ALLOC, 20'd0,      2'd3, 8'hFF);  // zero-byte request
      offer_request(MODE_ALLOC, 20'd16,     2'd0, 8'd0);   // exact fit, shelf 0
      offer_request(MODE_ALLOC, 20'd17,     2'd0, 8'd0);   // spills to shelf 1
      offer_request(MODE_ALLOC, 20'd64,     2'd0, 8'd0);
      offer_request(MODE_ALLOC, 20'd128,    2'd0, 8'd0);   // largest shelf, exact
      offer_request(MODE_ALLOC, 20'd129,    2'd0, 8'd0);   // nothing fits
      offer_request(MODE_ALLOC, 20'hFFFFF,  2'd1, 8'd7);   // max request, nothing fits
      offer_request(MODE_FREE,  20'hFFFFF,  2'd0, 8'd0);
      offer_request(MODE_ALLOC, 20'd1,      2'd0, 8'd0);   // pops the freed chunk
      offer_request(MODE_FREE,  20'd0,      2'd0, 8'd5);
      offer_request(MODE_FREE,  20'd0,      2'd0, 8'd5);   // double free
      offer_request(MODE_ALLOC, 20'd16,     2'd0, 8'd0);
      offer_request(MODE_ALLOC, 20'd16,     2'd0, 8'd0);   // same chunk again
      offer_request(MODE_FREE,  20'd0,      2'd3, 8'd255); // top chunk number
      for (int s = 0; s < ACTIVE_SHELVES; s++)
         offer_request(MODE_QUERY, 20'd0, SHELF_W'(s), 8'd0);
      offer_request(MODE_QUERY_ALT, 20'd0, 2'd2, 8'd0);    // undefined mode

      run_traffic(150, MIX_BALANCED);
      // long receiver stall while the sender keeps offering beats
      hold_off_req = 1'b1;
      run_traffic(40, MIX_BALANCED);
      drain_results();                                     // sender waits for everything
      run_traffic(110, MIX_BALANCED);

      // Tiny shelves: empty shelves and out-of-range frees become common
      configure_pool(5'd4, 5'd6, 5'd8, 5'd16, 9'd0, 9'd1, 9'd3, 9'd8);
      offer_request(MODE_ALLOC, 20'd10,    2'd0, 8'd0);    // shelf with no chunks
      offer_request(MODE_ALLOC, 20'd17,    2'd0, 8'd0);
      offer_request(MODE_ALLOC, 20'd33,    2'd0, 8'd0);    // shelf 1 now empty
      offer_request(MODE_FREE,  20'd0,     2'd1, 8'd200);  // beyond count: ignored
      offer_request(MODE_ALLOC, 20'd65536, 2'd0, 8'd0);
      offer_request(MODE_ALLOC, 20'd65537, 2'd0, 8'd0);
      run_traffic(245, MIX_BALANCED);

      // Sizes out of order and out of range; counts above the cap
      configure_pool(5'd16, 5'd3, 5'd0, 5'd31, 9'd511, 9'd5, 9'd300, 9'd2);
      run_traffic(250, MIX_BALANCED);

      // Full shelves, free storm on the last one
      configure_pool(5'd4, 5'd5, 5'd6, 5'd7, 9'd256, 9'd256, 9'd256, 9'd256);
      run_traffic(400, MIX_FREE_HEAVY);

      // All shelves at the minimum size
      configure_pool(5'd4, 5'd4, 5'd4, 5'd4, 9'd1, 9'd256, 9'd0, 9'd256);
      run_traffic(100, MIX_BALANCED);

      drain_results();
      $display("Covered %0d request beats (%0d allocate, %0d free, %0d query)",
               sb.n_alloc + sb.n_free + sb.n_query, sb.n_alloc, sb.n_free, sb.n_query);
      $display("over %0d pool settings; %0d beats checked, %0d empty, %0d no-fit.",
               sb.n_settings, sb.checked, sb.n_empty, sb.n_no_shelf);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("** size_class_pool_allocator_unit: PASSED **");
      else
         $display("** size_class_pool_allocator_unit: FAILED **");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #10_000_000;
      $display("timeout with %0d response beats outstanding", sb.pending());
      $display("** size_class_pool_allocator_unit: FAILED **");
      $finish;
   end

endmodule
